@@ hw/rtl/etpd_pkg.sv @@
package etpd_pkg;

  // Field widths.
  localparam int SAMPLE_W    = 16;
  localparam int AVG_W       = 32;
  localparam int SMOOTH_W    = 17;
  localparam int THRESH_W    = 16;
  localparam int WLEN_W      = 7;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_INDEX_W = 2;

  // Operand and product widths of the shared multiplier.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  localparam int DEF_MAX_WINDOW = 64;

  // Unity in Q1.16 and in Q5.12.
  localparam logic [SMOOTH_W-1:0] SMOOTH_ONE = 17'd65536;
  localparam logic [MUL_B_W-1:0]  THRESH_ONE = 17'd4096;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN_LEN   = 2'd2;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic        [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

endpackage

@@ hw/rtl/ema_threshold_peak_detector_unit.sv @@
// Threshold-triggered peak detector over an exponential moving average.
//
// Input channel (in_valid, in_stall, in_sample): one signed sample per item.
// Result channel (out_valid, out_stall, out_*): results carry the integer
// part of the average, a peak flag and a last-of-run mark for the item.
// Configuration port (cfg_we, cfg_index, cfg_data): plain register writes.
//
// Each sample runs through one shared multiplier twice, once for the average
// update and once for the threshold product, so the sequencer holds in_stall
// high while it steps through its multiply, add, multiply and compare states
// after an item is taken; a search result is loaded from the compare state.
// When a sample crosses the threshold a window opens and results are held in
// a MAX_WINDOW-entry memory until the window is full; the window is then read
// out one result at a time, each by a registered memory read and then a load
// of the output register, and no item is taken during that read-out.
// A stalled receiver simply holds the output register; the sequencer waits
// in front of it, so nothing is dropped or repeated.
// Reset clears the average, the window state and the registers to their
// defaults; the window memory needs no clearing since it is always written
// before it is read.
module ema_threshold_peak_detector_unit
  import etpd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_W-1:0]    in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_peak_flag,
  output logic signed [SAMPLE_W-1:0]    out_average,
  output logic                          out_last_of_run,
  input  logic                          cfg_we,
  input  logic        [CFG_INDEX_W-1:0] cfg_index,
  input  logic        [CFG_DATA_W-1:0]  cfg_data
);

  // Count width holds MAX_WINDOW itself; the address width only indexes it.
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL1    = 3'd1;
  localparam logic [2:0] S_ADD     = 3'd2;
  localparam logic [2:0] S_MUL2    = 3'd3;
  localparam logic [2:0] S_CMP     = 3'd4;
  localparam logic [2:0] S_EMIT_RD = 3'd5;
  localparam logic [2:0] S_EMIT_LD = 3'd6;

  logic [2:0]                 state_r, state_nxt;
  logic [SMOOTH_W-1:0]        smooth_r, smooth_nxt;
  logic [THRESH_W-1:0]        thresh_r, thresh_nxt;
  logic [WLEN_W-1:0]          wlen_r, wlen_nxt;
  logic signed [SAMPLE_W-1:0] x_r, x_nxt;
  logic signed [AVG_W-1:0]    avg_r, avg_nxt;
  logic                       in_window_r, in_window_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [SAMPLE_W-1:0] peak_max_r, peak_max_nxt;
  logic [AW-1:0]              peak_pos_r, peak_pos_nxt;
  logic [CW-1:0]              emit_idx_r, emit_idx_nxt;
  logic [CW-1:0]              emit_len_r, emit_len_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_flag_r, out_flag_nxt;
  logic signed [SAMPLE_W-1:0] out_avg_r, out_avg_nxt;
  logic                       out_last_r, out_last_nxt;
  logic [SAMPLE_W-1:0]        rd_data_r;

  logic [SAMPLE_W-1:0]        win_mem [MAX_WINDOW];
  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;

  mul_a_t                     mul_a;
  mul_b_t                     mul_b;
  prod_t                      prod;
  logic                       mul_en;

  logic [SMOOTH_W-1:0]        smooth_eff;
  logic [CW-1:0]              len_eff;
  logic signed [PROD_W-1:0]   lhs;
  logic                       trigger;
  logic                       out_free;
  logic [CW-1:0]              cnt_upd;
  logic                       start_emit;

  // Out-of-range settings are clamped rather than rejected.
  assign smooth_eff = (smooth_r > SMOOTH_ONE) ? SMOOTH_ONE : smooth_r;

  always_comb begin
    if (wlen_r == '0) begin
      len_eff = CW'(1);
    end else if (wlen_r > WLEN_W'(MAX_WINDOW)) begin
      len_eff = CW'(MAX_WINDOW);
    end else begin
      len_eff = wlen_r[CW-1:0];
    end
  end

  // The first pass multiplies the smoothing weight by the gap between the
  // sample (scaled to Q16.16) and the average; the second pass multiplies
  // the updated average by one plus the threshold factor.
  always_comb begin
    if (state_r == S_MUL1) begin
      mul_a = MUL_A_W'($signed({x_r, 16'b0})) - MUL_A_W'(avg_r);
      mul_b = MUL_B_W'(smooth_eff);
    end else begin
      mul_a = MUL_A_W'(avg_r);
      mul_b = THRESH_ONE + MUL_B_W'(thresh_r);
    end
  end

  assign mul_en = (state_r == S_MUL1) || (state_r == S_MUL2);

  etpd_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // The sample scaled by 2^28 set against avg * (1 + factor) in Q16.16 x Q5.12.
  assign lhs     = PROD_W'($signed({x_r, 28'b0}));
  assign trigger = lhs > prod;

  assign out_free = !out_valid_r || !out_stall;
  assign cnt_upd  = cnt_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    smooth_nxt    = smooth_r;
    thresh_nxt    = thresh_r;
    wlen_nxt      = wlen_r;
    x_nxt         = x_r;
    avg_nxt       = avg_r;
    in_window_nxt = in_window_r;
    cnt_nxt       = cnt_r;
    peak_max_nxt  = peak_max_r;
    peak_pos_nxt  = peak_pos_r;
    emit_idx_nxt  = emit_idx_r;
    emit_len_nxt  = emit_len_r;
    out_valid_nxt = out_valid_r;
    out_flag_nxt  = out_flag_r;
    out_avg_nxt   = out_avg_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    start_emit    = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = in_sample;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        // Bits 47:16 of the product are the floor of product / 65536.
        avg_nxt   = avg_r + prod[47:16];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (!in_window_r) begin
          if (trigger) begin
            mem_we        = 1'b1;
            mem_waddr     = '0;
            in_window_nxt = 1'b1;
            cnt_nxt       = CW'(1);
            peak_max_nxt  = x_r;
            peak_pos_nxt  = '0;
            if (len_eff <= CW'(1)) begin
              start_emit = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end else if (out_free) begin
            out_valid_nxt = 1'b1;
            out_flag_nxt  = 1'b0;
            out_avg_nxt   = avg_r[31:16];
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          if (cnt_r < CW'(MAX_WINDOW)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_r[AW-1:0];
            // Strictly greater, so the earliest of equal peaks is kept.
            if (x_r > peak_max_r) begin
              peak_max_nxt = x_r;
              peak_pos_nxt = cnt_r[AW-1:0];
            end
            cnt_nxt = cnt_upd;
            if (cnt_upd >= len_eff) begin
              start_emit = 1'b1;
            end else begin
              state_nxt = S_IDLE;
            end
          end else if (cnt_r >= len_eff) begin
            start_emit = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
        if (start_emit) begin
          in_window_nxt = 1'b0;
          cnt_nxt       = '0;
          emit_idx_nxt  = '0;
          emit_len_nxt  = len_eff;
          state_nxt     = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_flag_nxt  = (emit_idx_r == CW'(peak_pos_r));
          out_avg_nxt   = rd_data_r;
          out_last_nxt  = (emit_idx_r == emit_len_r - CW'(1));
          if (emit_idx_r == emit_len_r - CW'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            emit_idx_nxt = emit_idx_r + CW'(1);
            state_nxt    = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Writes must arrive only while idle; the block itself does not enforce it.
    // A threshold or length write drops an open window and resumes searching.
    if (cfg_we) begin
      case (cfg_index)
        REG_SMOOTHING: begin
          smooth_nxt = cfg_data;
        end
        REG_THRESHOLD: begin
          thresh_nxt    = cfg_data[THRESH_W-1:0];
          in_window_nxt = 1'b0;
          cnt_nxt       = '0;
        end
        REG_WIN_LEN: begin
          wlen_nxt      = cfg_data[WLEN_W-1:0];
          in_window_nxt = 1'b0;
          cnt_nxt       = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      smooth_r    <= SMOOTH_W'(66);
      thresh_r    <= THRESH_W'(28672);
      wlen_r      <= WLEN_W'(64);
      avg_r       <= '0;
      in_window_r <= 1'b0;
      cnt_r       <= '0;
      peak_pos_r  <= '0;
      emit_idx_r  <= '0;
      emit_len_r  <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      smooth_r    <= smooth_nxt;
      thresh_r    <= thresh_nxt;
      wlen_r      <= wlen_nxt;
      avg_r       <= avg_nxt;
      in_window_r <= in_window_nxt;
      cnt_r       <= cnt_nxt;
      peak_pos_r  <= peak_pos_nxt;
      emit_idx_r  <= emit_idx_nxt;
      emit_len_r  <= emit_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    peak_max_r <= peak_max_nxt;
    out_flag_r <= out_flag_nxt;
    out_avg_r  <= out_avg_nxt;
    out_last_r <= out_last_nxt;
  end

  // Window memory: one write port from the compare step, one registered
  // read port for the read-out.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[mem_waddr] <= avg_r[31:16];
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= win_mem[emit_idx_r[AW-1:0]];
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_peak_flag   = out_flag_r;
  assign out_average     = out_avg_r;
  assign out_last_of_run = out_last_r;

  // An open window seen between items has taken at least one sample and is
  // not yet full.
  a_window_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_window_r) |-> (cnt_r != '0 && cnt_r < len_eff))
    else $error("window count out of range while idle");

  // The read-out starts with the window state already cleared.
  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD) |-> (!in_window_r && cnt_r == '0))
    else $error("window still open during read-out");

  // The read-out index never passes the captured window length.
  a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD || state_r == S_EMIT_LD) |-> (emit_idx_r < emit_len_r))
    else $error("read-out index beyond window length");

  // A result only appears after the compare step or a read-out load.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_CMP || $past(state_r) == S_EMIT_LD))
    else $error("result loaded from an unexpected step");

endmodule

@@ hw/rtl/etpd_mul.sv @@
module etpd_mul
  import etpd_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  mul_a_t op_a,
  input  mul_b_t op_b,
  output prod_t  prod
);

  prod_t prod_r;

  // Signed operand times unsigned operand, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(op_a) * PROD_W'($signed({1'b0, op_b}));
    end
  end

  assign prod = prod_r;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

// One result as it leaves the detector: the flag, the integer part of the
// average and the mark on the last result caused by an item.
typedef struct {
  logic               peak_flag;
  logic signed [15:0] average;
  logic               last_of_run;
} peak_result_t;

// Tracks the detector's behaviour item by item and keeps the results that
// are still owed by the block, oldest first.
class ema_peak_checker;
  logic [etpd_pkg::SMOOTH_W-1:0] smoothing;
  logic [etpd_pkg::THRESH_W-1:0] thresh;
  logic [etpd_pkg::WLEN_W-1:0]   win_len;
  bit                            in_win;
  logic signed [31:0]            avg_q;
  logic signed [15:0]            win_avg [64];
  int                            win_count;
  logic signed [15:0]            peak_max;
  int                            peak_pos;
  peak_result_t                  owed_results [$];
  int                            errors;

  function new();
    smoothing = 17'd66;
    thresh    = 16'd28672;
    win_len   = 7'd64;
    in_win    = 1'b0;
    avg_q     = '0;
    win_count = 0;
    peak_max  = '0;
    peak_pos  = 0;
    errors    = 0;
  endfunction

  function int pending();
    return owed_results.size();
  endfunction

  // A threshold or length write abandons an open window and its results.
  function void write_reg(logic [etpd_pkg::CFG_INDEX_W-1:0] idx,
                          logic [etpd_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      etpd_pkg::REG_SMOOTHING: smoothing = data;
      etpd_pkg::REG_THRESHOLD: begin
        thresh    = data[15:0];
        in_win    = 1'b0;
        win_count = 0;
      end
      etpd_pkg::REG_WIN_LEN: begin
        win_len   = data[6:0];
        in_win    = 1'b0;
        win_count = 0;
      end
      default: ;
    endcase
  endfunction

  function int window_size();
    int len;
    len = int'(win_len);
    if (len == 0) len = 1;
    if (len > 64) len = 64;
    return len;
  endfunction

  function void release_window(int len);
    for (int k = 0; k < len; k++)
      owed_results.push_back(peak_result_t'{k == peak_pos, win_avg[k], k == len - 1});
    in_win    = 1'b0;
    win_count = 0;
  endfunction

  function void note_sample(logic signed [15:0] x);
    longint             weight;
    longint             delta;
    longint             lhs;
    longint             rhs;
    int                 len;
    logic signed [15:0] avg_int;
    len    = window_size();
    weight = (smoothing > 17'd65536) ? 64'sd65536 : longint'(smoothing);
    delta  = longint'(x) * 64'sd65536 - longint'(avg_q);
    // An arithmetic shift of the product floors towards minus infinity.
    avg_q   = longint'(avg_q) + ((weight * delta) >>> 16);
    avg_int = avg_q[31:16];
    if (!in_win) begin
      lhs = longint'(x) * 64'sd268435456;
      rhs = longint'(avg_q) * (64'sd4096 + longint'(thresh));
      if (lhs > rhs) begin
        in_win     = 1'b1;
        win_avg[0] = avg_int;
        win_count  = 1;
        peak_max   = x;
        peak_pos   = 0;
        if (win_count >= len) release_window(len);
      end else begin
        owed_results.push_back(peak_result_t'{1'b0, avg_int, 1'b1});
      end
      return;
    end
    if (win_count < 64) begin
      win_avg[win_count] = avg_int;
      // Strictly greater only, so the earliest of equal peaks is kept.
      if (x > peak_max) begin
        peak_max = x;
        peak_pos = win_count;
      end
      win_count++;
    end
    if (win_count >= len) release_window(len);
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 60) $display("mismatch: %s", msg);
  endtask

  task check_result(logic flag, logic signed [15:0] average, logic last);
    peak_result_t want;
    if (owed_results.size() == 0) begin
      report($sformatf("unexpected result flag %0b average %0d last %0b",
                       flag, average, last));
      return;
    end
    want = owed_results.pop_front();
    if (flag !== want.peak_flag)
      report($sformatf("peak_flag %0b, expected %0b", flag, want.peak_flag));
    if (average !== want.average)
      report($sformatf("average %0d, expected %0d", average, want.average));
    if (last !== want.last_of_run)
      report($sformatf("last_of_run %0b, expected %0b", last, want.last_of_run));
  endtask
endclass

module tb_top;
  import etpd_pkg::*;

  // Cycles allowed after the last owed result for an item that is still in
  // the block's sequencer without causing any result.
  localparam int SETTLE_CYCLES = 16;
  // A bound on the run, well above what a correct run needs.
  localparam int CYCLE_LIMIT = 400000;
  // An index that names no register; a write to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_peak_flag;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       out_last_of_run;
  logic                       cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  ema_peak_checker detector_model = new();

  ema_threshold_peak_detector_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_peak_flag   (out_peak_flag),
    .out_average     (out_average),
    .out_last_of_run (out_last_of_run),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // A run that stops making progress ends here rather than hanging.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[ema_threshold_peak_detector_unit] ERROR");
      $finish;
    end
  end

  // Result side. Values read straight after the edge are those the block saw
  // at that edge, so an item is taken exactly when valid was high and the
  // stall that we drove was low. The stall for the next edge is then drawn
  // afresh, independently of valid.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      detector_model.check_result(out_peak_flag, out_average, out_last_of_run);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Drives one register write; the enable stays high so that back-to-back
  // writes never lower and raise it within one time step. The caller drops
  // it once the group of writes is done.
  task write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    detector_model.write_reg(idx, data);
  endtask

  // Offers one sample, after a random idle gap, and returns at the edge at
  // which the block takes it. Valid is left high so that the next item can
  // follow without a gap.
  task push_sample(logic signed [15:0] value);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    do @(posedge clk); while (in_stall);
    detector_model.note_sample(value);
  endtask

  // Holds the sender off until every owed result has arrived, then lets the
  // block finish any item that is still working its way through a window.
  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (detector_model.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Samples mostly hover round a baseline with the odd spike above it, so
  // that windows open from a settled average; the rest are extremes and
  // values from the whole signed range.
  function automatic logic signed [15:0] pick_sample(int level);
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 50) begin
      value = level + int'($urandom_range(64)) - 32;
    end else if (pick < 65) begin
      value = int'($urandom_range(32767, 4096));
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0: value = -32768;
        1: value = 32767;
        2: value = 0;
        default: value = -1;
      endcase
    end else begin
      value = int'($urandom_range(65535)) - 32768;
    end
    if (value > 32767) value = 32767;
    if (value < -32768) value = -32768;
    return 16'(value);
  endfunction

  // One setting of the registers with one pattern of idling on both sides.
  // Every phase begins from an idle block; if it ends inside a window, the
  // threshold write of the next phase abandons that window.
  task run_phase(int smooth, int factor, int length, int idle, int stall, int count);
    int level;
    wait_drained();
    write_register(REG_SMOOTHING, CFG_DATA_W'(smooth));
    write_register(REG_THRESHOLD, CFG_DATA_W'(factor));
    write_register(REG_WIN_LEN, CFG_DATA_W'(length));
    cfg_we    <= 1'b0;
    idle_pct  = idle;
    stall_pct = stall;
    level     = int'($urandom_range(6000)) - 1000;
    for (int i = 0; i < count; i++) begin
      push_sample(pick_sample(level));
      // Now and then the sender waits for the block to empty completely.
      if (i == count / 2 && idle == 23) wait_drained();
    end
  endtask

  initial begin
    logic signed [15:0] opening_run [14] = '{
      0, -1, 1, -32768, -32768, 32767, 32767, 100, 1, 32767, -32768, 32767,
      32766, 5
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening with the reset settings and a short window: the
    // extremes of the sample, a negative average that lets a small positive
    // sample open a window, and a tie for the peak inside one.
    write_register(REG_WIN_LEN, CFG_DATA_W'(3));
    cfg_we <= 1'b0;
    foreach (opening_run[i]) push_sample(opening_run[i]);

    // A window left open across idle time: a smoothing write must leave it
    // running, while a threshold write must drop its withheld results.
    wait_drained();
    write_register(REG_WIN_LEN, CFG_DATA_W'(8));
    cfg_we <= 1'b0;
    for (int k = 0; k < 4 && !detector_model.in_win; k++) push_sample(SAMPLE_W'(32767));
    push_sample(SAMPLE_W'(-7));
    push_sample(SAMPLE_W'(32767));
    wait_drained();
    write_register(REG_SMOOTHING, CFG_DATA_W'(65536));
    cfg_we <= 1'b0;
    push_sample(SAMPLE_W'(-5));
    push_sample(SAMPLE_W'(12));
    wait_drained();
    write_register(REG_THRESHOLD, CFG_DATA_W'(0));
    write_register(REG_SPARE, 17'h1FFFF);
    cfg_we <= 1'b0;

    // Random phases, sweeping the registers through their extremes: no
    // smoothing, full smoothing and values above one, zero and largest
    // factors, and window lengths of zero, one, the maximum and beyond it.
    run_phase(4096,   4096,  4,   0,  0,  60);
    run_phase(65536,  0,     1,   69, 0,  50);
    run_phase(131071, 65535, 0,   0,  69, 50);
    run_phase(0,      28672, 64,  23, 23, 70);
    run_phase(1024,   8192,  127, 0,  0,  70);
    run_phase(66,     2048,  7,   69, 0,  60);
    run_phase(16384,  12288, 2,   0,  69, 60);
    run_phase(2000,   40000, 16,  23, 23, 60);

    wait_drained();
    if (detector_model.errors == 0) begin
      $display("[ema_threshold_peak_detector_unit] OK");
    end else begin
      $display("[ema_threshold_peak_detector_unit] ERROR");
    end
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/etpd_pkg.sv
hw/rtl/etpd_mul.sv
hw/rtl/ema_threshold_peak_detector_unit.sv
sim/tb_top.sv
